>>> rtl/rau_pkg.sv
// Shared types and codes for the rational arithmetic unit.
`default_nettype none
package rau_pkg;
    localparam logic [1:0] FUNC_ADD = 2'd0;
    localparam logic [1:0] FUNC_SUB = 2'd1;
    localparam logic [1:0] FUNC_MUL = 2'd2;
    localparam logic [1:0] FUNC_DIV = 2'd3;

    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic combine;
        logic gcd_init;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic finish;
    } rau_cmd_t;

    typedef struct packed {
        logic den_zero;
        logic num_zero;
        logic gcd_done;
        logic div_done;
    } rau_sts_t;
endpackage
`default_nettype wire

>>> rtl/rau_datapath.sv
// Datapath: cross products, binary GCD and restoring division of both terms.
`default_nettype none
module rau_datapath #(
    parameter int WORD_BITS = 32
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  rau_pkg::rau_cmd_t   cmd,
    output rau_pkg::rau_sts_t   sts,
    input  wire  [1:0]          func,
    input  wire  [31:0]         a_num,
    input  wire  [31:0]         a_den,
    input  wire  [31:0]         b_num,
    input  wire  [31:0]         b_den,
    output logic [31:0]         res_num,
    output logic [31:0]         res_den,
    output logic                zero_den_error
);
    import rau_pkg::*;
    localparam int W = WORD_BITS;
    localparam int CW = $clog2(W + 1);
    localparam int IW = $clog2(W);

    logic [1:0]   func_reg;
    logic [W-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic [W-1:0] p0_reg, p1_reg, p2_reg;
    logic [W-1:0] num_reg, den_reg;
    logic [W-1:0] gx_reg, gy_reg;
    logic [CW-1:0] shift_reg;
    logic [W-1:0] g_reg;
    logic [W-1:0] qn_reg, rn_reg, qd_reg, rd_reg;
    logic [CW-1:0] cnt_reg;
    logic          zero_reg;

    logic [W-1:0] abs_num, abs_den, gx_next, gy_next, diff;
    logic [W:0]   trn, trd;
    logic [W-1:0] dvd_n, dvd_d;
    logic [IW-1:0] bit_idx;

    always_comb
    begin
        abs_num = num_reg[W-1] ? -num_reg : num_reg;
        abs_den = den_reg[W-1] ? -den_reg : den_reg;
        dvd_n = num_reg[W-1] ? -num_reg : num_reg;
        dvd_d = den_reg[W-1] ? -den_reg : den_reg;
        diff = (gx_reg > gy_reg) ? gx_reg - gy_reg : gy_reg - gx_reg;
        gx_next = gx_reg;
        gy_next = gy_reg;
        if (!gx_reg[0] && !gy_reg[0])
        begin
            gx_next = gx_reg >> 1;
            gy_next = gy_reg >> 1;
        end
        else if (!gx_reg[0])
            gx_next = gx_reg >> 1;
        else if (!gy_reg[0])
            gy_next = gy_reg >> 1;
        else
        begin
            gx_next = (gx_reg < gy_reg) ? gx_reg : gy_reg;
            gy_next = diff >> 1;
        end
        bit_idx = IW'(cnt_reg - 1'b1);
        trn = {rn_reg, dvd_n[bit_idx]} - {1'b0, g_reg};
        trd = {rd_reg, dvd_d[bit_idx]} - {1'b0, g_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            zero_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            zero_reg <= (den_reg == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            an_reg <= a_num[W-1:0];
            ad_reg <= a_den[W-1:0];
            bn_reg <= b_num[W-1:0];
            bd_reg <= b_den[W-1:0];
        end
        if (cmd.mul1)
        begin
            p0_reg <= W'(an_reg * ((func_reg == FUNC_MUL) ? bn_reg : bd_reg));
            p1_reg <= W'(ad_reg * bn_reg);
        end
        if (cmd.mul2)
            p2_reg <= W'(ad_reg * bd_reg);
        if (cmd.combine)
        begin
            unique case (func_reg)
                FUNC_ADD: num_reg <= p0_reg + p1_reg;
                FUNC_SUB: num_reg <= p0_reg - p1_reg;
                FUNC_MUL: num_reg <= p0_reg;
                FUNC_DIV: num_reg <= p0_reg;
                default:  num_reg <= p0_reg;
            endcase
            den_reg <= (func_reg == FUNC_DIV) ? p1_reg : p2_reg;
        end
        if (cmd.gcd_init)
        begin
            gx_reg <= abs_num;
            gy_reg <= abs_den;
            shift_reg <= '0;
        end
        if (cmd.gcd_step)
        begin
            gx_reg <= gx_next;
            gy_reg <= gy_next;
            if (!gx_reg[0] && !gy_reg[0])
                shift_reg <= shift_reg + 1'b1;
        end
        if (cmd.div_init)
        begin
            g_reg <= gx_reg << shift_reg;
            rn_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= CW'(W);
        end
        if (cmd.div_step)
        begin
            if (!trn[W])
            begin
                rn_reg <= trn[W-1:0];
                qn_reg <= {qn_reg[W-2:0], 1'b1};
            end
            else
            begin
                rn_reg <= {rn_reg[W-2:0], dvd_n[bit_idx]};
                qn_reg <= {qn_reg[W-2:0], 1'b0};
            end
            if (!trd[W])
            begin
                rd_reg <= trd[W-1:0];
                qd_reg <= {qd_reg[W-2:0], 1'b1};
            end
            else
            begin
                rd_reg <= {rd_reg[W-2:0], dvd_d[bit_idx]};
                qd_reg <= {qd_reg[W-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    logic [W-1:0] on, od;
    always_comb
    begin
        sts.den_zero = (den_reg == '0);
        sts.num_zero = (num_reg == '0);
        sts.gcd_done = (gy_reg == '0);
        sts.div_done = (cnt_reg == '0);
        on = num_reg[W-1] ? -qn_reg : qn_reg;
        od = den_reg[W-1] ? -qd_reg : qd_reg;
        if (zero_reg)
        begin
            on = '0;
            od = '0;
        end
        else if (num_reg == '0)
        begin
            on = '0;
            od = W'(1);
        end
        res_num = 32'(signed'(on));
        res_den = 32'(signed'(od));
        zero_den_error = zero_reg;
    end
endmodule
`default_nettype wire

>>> rtl/rau_ctrl.sv
// Controller sequencing load, multiply, GCD, division and output.
`default_nettype none
module rau_ctrl (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire                out_ready,
    output rau_pkg::rau_cmd_t  cmd,
    input  rau_pkg::rau_sts_t  sts
);
    import rau_pkg::*;
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_MUL2 = 3'd2;
    localparam logic [2:0] S_COMB = 3'd3;
    localparam logic [2:0] S_CHK  = 3'd4;
    localparam logic [2:0] S_GCD  = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = (state_reg == S_IDLE);
        out_valid = (state_reg == S_OUT);
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_MUL1;
                end
            S_MUL1:
            begin
                cmd.mul1 = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2 = 1'b1;
                state_next = S_COMB;
            end
            S_COMB:
            begin
                cmd.combine = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                cmd.finish = 1'b1;
                if (sts.den_zero || sts.num_zero)
                    state_next = S_OUT;
                else
                begin
                    cmd.gcd_init = 1'b1;
                    state_next = S_GCD;
                end
            end
            S_GCD:
                if (sts.gcd_done)
                begin
                    cmd.div_init = 1'b1;
                    state_next = S_DIV;
                end
                else
                    cmd.gcd_step = 1'b1;
            S_DIV:
                if (sts.div_done)
                    state_next = S_OUT;
                else
                    cmd.div_step = 1'b1;
            S_OUT:
                if (out_ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

>>> rtl/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit.
// Usage:
//   Input channel in_valid/in_ready carries one request: func and two
//   fractions. Output channel out_valid/out_ready returns the reduced
//   fraction and zero_den_error.
//   Sequence: products in MUL1 and MUL2, combining in COMB, checks in CHK,
//   binary GCD steps, loading of the divisor, bit-serial division (both
//   terms at once), then the result is shown. The time per request is
//   set by the GCD loop and the two restoring dividers.
//   One request is in flight at a time; in_ready is high only when idle.
//   A zero result numerator or denominator skips GCD and division: the
//   controller goes from the check state to the output state.
//   When out_ready is low the result holds on the outputs.
//   Reset returns the controller to idle with no result pending.
`default_nettype none
module rational_arithmetic_unit #(
    parameter int WORD_BITS = 32
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [1:0]  func,
    input  wire  [31:0] a_num,
    input  wire  [31:0] a_den,
    input  wire  [31:0] b_num,
    input  wire  [31:0] b_den,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [31:0] res_num,
    output logic [31:0] res_den,
    output logic        zero_den_error
);
    import rau_pkg::*;
    rau_cmd_t cmd;
    rau_sts_t sts;

    rau_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
    );

    rau_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .func(func),
        .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
        .res_num(res_num), .res_den(res_den), .zero_den_error(zero_den_error)
    );
endmodule
`default_nettype wire

>>> rtl/rau_checker.sv
// Port-level checks for the rational arithmetic unit.
`default_nettype none
module rau_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        in_valid,
    input wire        in_ready,
    input wire        out_valid,
    input wire        out_ready,
    input wire [31:0] res_num,
    input wire [31:0] res_den,
    input wire        zero_den_error
);
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready while result pending");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_den_error |-> res_num == 32'd0 && res_den == 32'd0)
        else $error("error result not zero");
    a_den: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !zero_den_error |-> res_den != 32'd0)
        else $error("zero denominator without error");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(res_num))
        else $error("result dropped");
endmodule
bind rational_arithmetic_unit rau_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .res_num(res_num),
    .res_den(res_den), .zero_den_error(zero_den_error)
);
`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for the rational arithmetic unit.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import rau_pkg::*;

    typedef struct packed {
        logic [31:0] num;
        logic [31:0] den;
        logic        err;
    } fraction_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  func = FUNC_ADD;
    logic [31:0] a_num = '0;
    logic [31:0] a_den = '0;
    logic [31:0] b_num = '0;
    logic [31:0] b_den = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] res_num;
    logic [31:0] res_den;
    logic        zero_den_error;

    fraction_t   expected_q[$];
    int          mismatches = 0;
    int          cycles = 0;
    int          hold_cycles = 0;
    bit          stall_en = 1'b1;

    rational_arithmetic_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
        .out_valid(out_valid), .out_ready(out_ready),
        .res_num(res_num), .res_den(res_den), .zero_den_error(zero_den_error)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2000000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [63:0] abs_word(logic signed [31:0] v);
        logic [63:0] r;
        r = v < 0 ? -64'(v) : 64'(v);
        return r;
    endfunction

    function automatic fraction_t reduce_fraction(logic [1:0] op, logic [31:0] an,
        logic [31:0] ad, logic [31:0] bn, logic [31:0] bd);
        logic signed [31:0] n;
        logic signed [31:0] d;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] t;
        logic signed [63:0] g;
        fraction_t f;
        case (op)
            FUNC_ADD:
            begin
                n = an * bd + ad * bn;
                d = ad * bd;
            end
            FUNC_SUB:
            begin
                n = an * bd - ad * bn;
                d = ad * bd;
            end
            FUNC_MUL:
            begin
                n = an * bn;
                d = ad * bd;
            end
            default:
            begin
                n = an * bd;
                d = ad * bn;
            end
        endcase
        if (d == 0)
            f = '{32'd0, 32'd0, 1'b1};
        else if (n == 0)
            f = '{32'd0, 32'd1, 1'b0};
        else
        begin
            x = abs_word(n);
            y = abs_word(d);
            while (y != 0)
            begin
                t = x % y;
                x = y;
                y = t;
            end
            g = x;
            f.num = 32'(64'(n) / g);
            f.den = 32'(64'(d) / g);
            f.err = 1'b0;
        end
        return f;
    endfunction

    // receiver: random stall pattern, plus a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ready <= 1'b0;
        end
        else if (stall_en)
            out_ready <= ($urandom_range(0, 3) != 0);
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        fraction_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected result %h/%h err %b", res_num, res_den,
                        zero_den_error);
            end
            else
            begin
                e = expected_q.pop_front();
                if (e.num !== res_num || e.den !== res_den || e.err !== zero_den_error)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h/%h err %b, got %h/%h err %b",
                            e.num, e.den, e.err, res_num, res_den, zero_den_error);
                end
            end
        end
    end

    task automatic send_request(logic [1:0] op, logic [31:0] an, logic [31:0] ad,
        logic [31:0] bn, logic [31:0] bd);
        in_valid <= 1'b1;
        func <= op;
        a_num <= an;
        a_den <= ad;
        b_num <= bn;
        b_den <= bd;
        expected_q.push_back(reduce_fraction(op, an, ad, bn, bd));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic idle_sender(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain;
        idle_sender(1);
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 40);
            2: return -$urandom_range(0, 40);
            3: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
            4: return $urandom & 32'h0000_ffff;
            default: return $urandom_range(1, 1000) * $urandom_range(1, 60);
        endcase
    endfunction

    task automatic test_directed;
        logic [1:0] op;
        for (int k = 0; k < 4; k++)
        begin
            op = k[1:0];
            send_request(op, 32'd1, 32'd2, 32'd1, 32'd3);
            send_request(op, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000);
            send_request(op, 32'd0, 32'd5, 32'd0, 32'd7);
            send_request(op, 32'd3, 32'd0, 32'd4, 32'd0);
            send_request(op, -32'd6, 32'd4, 32'd2, -32'd8);
        end
        send_request(FUNC_DIV, 32'd5, 32'd3, 32'd0, 32'd9);
        send_request(FUNC_MUL, 32'h0001_0000, 32'd1, 32'h0001_0000, 32'd1);
        send_request(FUNC_MUL, 32'd1, 32'h0001_0000, 32'd1, 32'h0001_0000);
        send_request(FUNC_SUB, 32'd7, 32'd9, 32'd7, 32'd9);
        drain();
    endtask

    task automatic test_random(int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 12);
            repeat (burst)
            begin
                send_request(2'($urandom_range(0, 3)), rand_word(), rand_word(),
                    rand_word(), rand_word());
                sent = sent + 1;
            end
            if ($urandom_range(0, 2) != 0)
                idle_sender($urandom_range(1, 40));
        end
        drain();
    endtask

    task automatic test_backpressure;
        hold_cycles = 600;
        repeat (6)
            send_request(2'($urandom_range(0, 3)), rand_word(), rand_word(),
                rand_word(), rand_word());
        drain();
        stall_en = 1'b0;
        repeat (40)
            send_request(2'($urandom_range(0, 3)), rand_word(), rand_word(),
                rand_word(), rand_word());
        drain();
        stall_en = 1'b1;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random(1750);
        repeat (300) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
rtl/rau_pkg.sv
rtl/rau_datapath.sv
rtl/rau_ctrl.sv
rtl/rational_arithmetic_unit.sv
rtl/rau_checker.sv
verif/testbench.sv
